[hw/rtl/ezr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_pkg: shared constants and tables
// Widths, CORDIC arctangent table and gain for the Euler vector rotation.
// ----------------------------------------------------------------------------
package ezr_pkg;
    localparam int ANGLE_BITS   = 16;
    localparam int VEC_BITS     = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    // CORDIC datapath width: Q30 values with headroom for gain growth.
    localparam int CW = 34;
    localparam int ZW = 33;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    typedef logic signed [CW-1:0] t_cv;
    typedef logic signed [ZW-1:0] t_zv;
    typedef logic signed [VEC_BITS-1:0] t_vec;

    typedef struct packed {
        t_vec n;
        t_vec e;
        t_vec d;
        logic signed [ANGLE_BITS-1:0] roll;
        logic signed [ANGLE_BITS-1:0] pitch;
        logic signed [ANGLE_BITS-1:0] yaw;
    } t_in;

    typedef struct packed {
        t_vec x;
        t_vec y;
        t_vec z;
        logic sat;
    } t_out;

    function automatic t_zv atan_phase(input int i);
        unique case (i)
            0:  atan_phase = ZW'(32'h20000000);
            1:  atan_phase = ZW'(32'h12E4051E);
            2:  atan_phase = ZW'(32'h09FB385B);
            3:  atan_phase = ZW'(32'h051111D4);
            4:  atan_phase = ZW'(32'h028B0D43);
            5:  atan_phase = ZW'(32'h0145D7E1);
            6:  atan_phase = ZW'(32'h00A2F61E);
            7:  atan_phase = ZW'(32'h00517C55);
            8:  atan_phase = ZW'(32'h0028BE53);
            9:  atan_phase = ZW'(32'h00145F2F);
            10: atan_phase = ZW'(32'h000A2F98);
            11: atan_phase = ZW'(32'h000517CC);
            12: atan_phase = ZW'(32'h00028BE6);
            13: atan_phase = ZW'(32'h000145F3);
            14: atan_phase = ZW'(32'h0000A2FA);
            15: atan_phase = ZW'(32'h0000517D);
            16: atan_phase = ZW'(32'h000028BE);
            17: atan_phase = ZW'(32'h0000145F);
            18: atan_phase = ZW'(32'h00000A30);
            19: atan_phase = ZW'(32'h00000518);
            20: atan_phase = ZW'(32'h0000028C);
            21: atan_phase = ZW'(32'h00000146);
            22: atan_phase = ZW'(32'h000000A3);
            default: atan_phase = ZW'(32'h00000051);
        endcase
    endfunction

    // Q30 product rounded half up: floor((a*b + 2^29) / 2^30).
    function automatic t_cv mulq(input t_cv a, input t_cv b);
        logic signed [2*CW-1:0] p;
        p = a * b + (2*CW)'(64'sd536870912);
        mulq = CW'(p >>> 30);
    endfunction
endpackage
`default_nettype wire

[hw/rtl/ezr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_if: valid/ready channel interfaces
// Input, output and configuration channels of the rotation block.
// ----------------------------------------------------------------------------
interface ezr_in_if;
    logic            valid;
    logic            ready;
    ezr_pkg::t_in    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ezr_out_if;
    logic            valid;
    logic            ready;
    ezr_pkg::t_out   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ezr_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/ezr_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_cordic: pipelined sine/cosine
// Quadrant reduction followed by one register stage per CORDIC iteration.
// ----------------------------------------------------------------------------
module ezr_cordic (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire logic [ezr_pkg::ANGLE_BITS-1:0] i_angle,
    output ezr_pkg::t_cv                        o_sin,
    output ezr_pkg::t_cv                        o_cos
);
    import ezr_pkg::*;

    t_cv  r_x [STEPS+1];
    t_cv  r_y [STEPS+1];
    t_zv  r_z [STEPS+1];
    logic r_flip [STEPS+1];

    logic [31:0] ph;
    logic [31:0] ph_red;
    logic        flip;

    always_comb begin
        ph     = {i_angle, {(32-ANGLE_BITS){1'b0}}};
        flip   = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
        ph_red = flip ? (ph + 32'h80000000) : ph;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= ZW'($signed(ph_red));
            r_flip[0] <= flip;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_phase(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_phase(i);
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    assign o_cos = r_flip[STEPS] ? -r_x[STEPS] : r_x[STEPS];
    assign o_sin = r_flip[STEPS] ? -r_y[STEPS] : r_y[STEPS];
endmodule
`default_nettype wire

[hw/rtl/ezr_matrix.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_matrix: rotation matrix and vector product
// Two multiply stages build R, a third forms the entry-by-component products,
// and a fourth sums, rounds and saturates.
// ----------------------------------------------------------------------------
module ezr_matrix (
    input  wire                i_clk,
    input  wire                i_en,
    input  wire                i_dir,
    input  wire ezr_pkg::t_cv  i_sr,
    input  wire ezr_pkg::t_cv  i_cr,
    input  wire ezr_pkg::t_cv  i_sp,
    input  wire ezr_pkg::t_cv  i_cp,
    input  wire ezr_pkg::t_cv  i_sy,
    input  wire ezr_pkg::t_cv  i_cy,
    input  wire ezr_pkg::t_vec i_v [3],
    output ezr_pkg::t_out      o_res
);
    import ezr_pkg::*;

    localparam int PW = CW + VEC_BITS + 2;
    localparam logic signed [PW-1:0] VMAX = {{(PW-VEC_BITS+1){1'b0}}, {(VEC_BITS-1){1'b1}}};
    localparam logic signed [PW-1:0] VMIN = {{(PW-VEC_BITS+1){1'b1}}, {(VEC_BITS-1){1'b0}}};

    // Stage A: first-level products.
    t_cv  r_a_spsr, r_a_spcr, r_a_cycp, r_a_sycr, r_a_sysr, r_a_sycp;
    t_cv  r_a_cycr, r_a_cysr, r_a_cpsr, r_a_cpcr, r_a_sp, r_a_sy, r_a_cy;
    t_vec r_a_v [3];
    logic r_a_dir;
    // Stage B: matrix.
    t_cv  r_m [3][3];
    t_vec r_b_v [3];
    logic r_b_dir;
    // Stage C: products of row entries by components.
    logic signed [PW-1:0] r_p [3][3];
    // Stage D: result.
    t_out r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_spsr <= mulq(i_sp, i_sr);
            r_a_spcr <= mulq(i_sp, i_cr);
            r_a_cycp <= mulq(i_cy, i_cp);
            r_a_sycr <= mulq(i_sy, i_cr);
            r_a_sysr <= mulq(i_sy, i_sr);
            r_a_sycp <= mulq(i_sy, i_cp);
            r_a_cycr <= mulq(i_cy, i_cr);
            r_a_cysr <= mulq(i_cy, i_sr);
            r_a_cpsr <= mulq(i_cp, i_sr);
            r_a_cpcr <= mulq(i_cp, i_cr);
            r_a_sp   <= i_sp;
            r_a_sy   <= i_sy;
            r_a_cy   <= i_cy;
            r_a_v    <= i_v;
            r_a_dir  <= i_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0][0] <= r_a_cycp;
            r_m[0][1] <= mulq(r_a_cy, r_a_spsr) - r_a_sycr;
            r_m[0][2] <= mulq(r_a_cy, r_a_spcr) + r_a_sysr;
            r_m[1][0] <= r_a_sycp;
            r_m[1][1] <= mulq(r_a_sy, r_a_spsr) + r_a_cycr;
            r_m[1][2] <= mulq(r_a_sy, r_a_spcr) - r_a_cysr;
            r_m[2][0] <= -r_a_sp;
            r_m[2][1] <= r_a_cpsr;
            r_m[2][2] <= r_a_cpcr;
            r_b_v     <= r_a_v;
            r_b_dir   <= r_a_dir;
        end
    end

    // The dot product is exact, so plain full-width products suffice.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= PW'(r_b_dir ? r_m[j][i] : r_m[i][j]) * PW'(r_b_v[j]);
                end
            end
        end
    end

    logic signed [PW-1:0] sum [3];
    logic signed [PW-1:0] rnd [3];
    logic                 hi  [3];
    logic                 lo  [3];
    t_out                 n_res;

    always_comb begin
        n_res = '0;
        for (int i = 0; i < 3; i++) begin
            sum[i] = r_p[i][0] + r_p[i][1] + r_p[i][2] + PW'(64'sd536870912);
            rnd[i] = sum[i] >>> 30;
            hi[i]  = rnd[i] > VMAX;
            lo[i]  = rnd[i] < VMIN;
        end
        n_res.x = hi[0] ? t_vec'({1'b0, {(VEC_BITS-1){1'b1}}})
                : lo[0] ? t_vec'({1'b1, {(VEC_BITS-1){1'b0}}}) : t_vec'(rnd[0]);
        n_res.y = hi[1] ? t_vec'({1'b0, {(VEC_BITS-1){1'b1}}})
                : lo[1] ? t_vec'({1'b1, {(VEC_BITS-1){1'b0}}}) : t_vec'(rnd[1]);
        n_res.z = hi[2] ? t_vec'({1'b0, {(VEC_BITS-1){1'b1}}})
                : lo[2] ? t_vec'({1'b1, {(VEC_BITS-1){1'b0}}}) : t_vec'(rnd[2]);
        n_res.sat = hi[0] | lo[0] | hi[1] | lo[1] | hi[2] | lo[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

[hw/rtl/euler_zyx_vector_rotation.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_zyx_vector_rotation: ZYX Euler attitude vector rotation
// Rotates a Q16.16 vector by R = Rz*Ry*Rx or its transpose.
//
//   channel   dir   payload
//   in        sink  vec_n/e/d, roll/pitch/yaw angle
//   out       src   out_x/y/z, saturated
//   cfg       sink  direction (reset 1 = transpose)
//
// One item per cycle unless the output stalls. Stages: reduction, one
// stage per CORDIC step, two matrix stages, product and sum stages.
// The whole pipeline advances together; it halts while the output holds
// an untaken result. Synchronous active-low reset clears valid bits and
// sets direction to 1.
// ----------------------------------------------------------------------------
module euler_zyx_vector_rotation (
    input  wire       i_clk,
    input  wire       i_rst_n,
    ezr_in_if.sink    in_ch,
    ezr_out_if.source out_ch,
    ezr_cfg_if.sink   cfg_ch
);
    import ezr_pkg::*;

    localparam int LAT = STEPS + 5;

    logic     r_dir;
    logic     r_vld [LAT];
    t_vec     r_v [STEPS+1][3];
    logic     en;
    t_cv      sr, cr, sp, cp, sy, cy;

    assign en           = !r_vld[LAT-1] || out_ch.ready;
    assign in_ch.ready  = en;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b1;
        end else if (cfg_ch.valid) begin
            r_dir <= cfg_ch.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= in_ch.valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // The vector rides alongside the CORDIC pipeline.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v[0][0] <= in_ch.data.n;
            r_v[0][1] <= in_ch.data.e;
            r_v[0][2] <= in_ch.data.d;
            for (int k = 1; k <= STEPS; k++) r_v[k] <= r_v[k-1];
        end
    end

    ezr_cordic u_roll  (.i_clk(i_clk), .i_en(en), .i_angle(in_ch.data.roll),
                        .o_sin(sr), .o_cos(cr));
    ezr_cordic u_pitch (.i_clk(i_clk), .i_en(en), .i_angle(in_ch.data.pitch),
                        .o_sin(sp), .o_cos(cp));
    ezr_cordic u_yaw   (.i_clk(i_clk), .i_en(en), .i_angle(in_ch.data.yaw),
                        .o_sin(sy), .o_cos(cy));

    ezr_matrix u_matrix (
        .i_clk(i_clk), .i_en(en), .i_dir(r_dir),
        .i_sr(sr), .i_cr(cr), .i_sp(sp), .i_cp(cp), .i_sy(sy), .i_cy(cy),
        .i_v(r_v[STEPS]), .o_res(out_ch.data)
    );
endmodule
`default_nettype wire

[hw/rtl/ezr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_checker: port-level checks
// Handshake and flow checks on the rotation block's channels.
// ----------------------------------------------------------------------------
module ezr_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire in_valid,
    input wire in_ready,
    input wire out_valid,
    input wire out_ready,
    input wire out_sat,
    input wire cfg_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_sat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_sat))
        else $error("saturation flag changed while stalled");
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_ready)
        else $error("config channel not ready");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid right after reset");
endmodule

bind euler_zyx_vector_rotation ezr_checker u_ezr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_sat(out_ch.data.sat), .cfg_ready(cfg_ch.ready)
);
`default_nettype wire
